// ----- src/difc_pkg.sv -----
// Constants, codes and types shared by the flow table core.
package difc_pkg;

  localparam int CAPACITY   = 256;
  localparam int HASH_LINES = 1024;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int PTR_W      = SLOT_W + 1;
  localparam int LINE_W     = $clog2(HASH_LINES);
  localparam int ID_W       = 16;
  localparam int REFS_W     = 16;
  localparam int KEY_W      = 32;
  localparam int CNT_W      = 9;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 3;

  localparam logic [ID_W-1:0]   FIRST_IDENT = ID_W'(1);
  localparam logic [ID_W-1:0]   LAST_IDENT  = ID_W'(65535);
  localparam logic [REFS_W-1:0] REFS_MAX     = '1;
  localparam logic [PTR_W-1:0]  NIL_PTR      = PTR_W'(CAPACITY);

  // free-slot scan granularity
  localparam int CHUNK_W     = 16;
  localparam int NUM_CHUNK   = CAPACITY / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNK);
  localparam int CHUNK_BIT_W = $clog2(CHUNK_W);

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 184;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET_KEY = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET_ID = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PUT    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DEL    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_KEY_EXISTS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  ident;
    logic [KEY_W-1:0] user_data;
    logic [KEY_W-1:0] key_c;
    logic [KEY_W-1:0] key_b;
    logic [KEY_W-1:0] key_a;
  } slot_t;

  localparam int SLOT_DATA_W = $bits(slot_t);

endpackage

// ----- src/difc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module difc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/dual_index_refcounted_flow_table_core.sv -----
// Flow table core: key and id hashed chains over slot memories, with refcounts.
//
// One request enters on the s_ channel, one result leaves on the m_ channel.
// Requests: add, get by key, get by id, put handle, delete by key, count.
// The block works on one request at a time. The state lives in six
// synchronous RAMs (slot data, refcounts, key/id chain links, key/id bucket
// heads); every chain step is one RAM read plus one compare.
// Steps: count goes straight to the result. Put reads the refcount and then
// updates it (a free slot is refused straight away). Get by key hashes the
// key and walks the key chain; get by id walks the id chain (id 0 is refused
// straight away); a hit then updates the refcount. Add: key lookup, free-slot
// scan (16 slots a cycle), an id chain walk for each id probed, then the
// write. Delete: lookup, unlink from the id chain and then the key chain, then
// the refcount update. After reset the bucket-head RAMs are swept to empty,
// one line a cycle, with s_tready low. Slot data is not cleared.
// The result sits in an output register; the next request is taken while it
// waits, but its result is held back until m_tready takes the earlier transfer.
module dual_index_refcounted_flow_table_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // func, key_a, key_b, key_c, user_data_in, lookup_id, handle_in, zero pad
  input  logic [difc_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, entry_id_out, handle_out, key_a_out, key_b_out, key_c_out,
  // user_data_out, refs_out, entries_in_use, zero pad
  output logic [difc_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_HASH1  = 5'd2;
  localparam logic [4:0] S_HASH2  = 5'd3;
  localparam logic [4:0] S_KHEAD  = 5'd4;
  localparam logic [4:0] S_KHD    = 5'd5;
  localparam logic [4:0] S_KWALK  = 5'd6;
  localparam logic [4:0] S_KCMP   = 5'd7;
  localparam logic [4:0] S_FREE   = 5'd8;
  localparam logic [4:0] S_IHEAD  = 5'd9;
  localparam logic [4:0] S_IHD    = 5'd10;
  localparam logic [4:0] S_IWALK  = 5'd11;
  localparam logic [4:0] S_ICMP   = 5'd12;
  localparam logic [4:0] S_ADDW   = 5'd13;
  localparam logic [4:0] S_REFRD  = 5'd14;
  localparam logic [4:0] S_REFUPD = 5'd15;
  localparam logic [4:0] S_UNX    = 5'd16;
  localparam logic [4:0] S_UHD    = 5'd17;
  localparam logic [4:0] S_UHDC   = 5'd18;
  localparam logic [4:0] S_UWK    = 5'd19;
  localparam logic [4:0] S_UWKC   = 5'd20;
  localparam logic [4:0] S_UEND   = 5'd21;
  localparam logic [4:0] S_PUTRD  = 5'd22;
  localparam logic [4:0] S_PUTC   = 5'd23;
  localparam logic [4:0] S_DONE   = 5'd24;

  localparam int SW = difc_pkg::SLOT_W;
  localparam int PW = difc_pkg::PTR_W;
  localparam int LW = difc_pkg::LINE_W;
  localparam int IW = difc_pkg::ID_W;
  localparam int RW = difc_pkg::REFS_W;
  localparam int KW = difc_pkg::KEY_W;

  logic [4:0] state;

  // latched request
  logic [difc_pkg::FUNC_W-1:0] op;
  logic [KW-1:0] ka, kb, kc, ud;

  logic [LW-1:0] ab, kline, clr_idx;
  logic [PW-1:0] cur, p, snext, khd_save, ihd_save;
  logic [SW-1:0] s;
  logic [IW-1:0] probe_id, next_ident;
  logic [difc_pkg::CHUNK_IDX_W-1:0] chunk;
  logic usel;  // 0: id chain, 1: key chain
  logic [difc_pkg::CAPACITY-1:0] inuse, linked;
  logic [difc_pkg::CNT_W-1:0] linked_count;

  // captured result
  logic [difc_pkg::STATUS_W-1:0] res_status;
  logic res_show;
  difc_pkg::slot_t res_slot;
  logic [RW-1:0] res_refs;

  // output register
  logic [difc_pkg::STATUS_W-1:0] o_status;
  logic [IW-1:0] o_id;
  logic [SW-1:0] o_handle;
  logic [KW-1:0] o_ka, o_kb, o_kc, o_ud;
  logic [RW-1:0] o_refs;
  logic [difc_pkg::CNT_W-1:0] o_cnt;

  // RAM ports
  logic slot_we;
  difc_pkg::slot_t slot_wdata, slot_rdata;
  logic refs_we;
  logic [RW-1:0] refs_wdata, refs_rdata;
  logic knext_we, inext_we;
  logic [SW-1:0] knext_waddr, inext_waddr, knext_raddr, inext_raddr;
  logic [PW-1:0] knext_wdata, inext_wdata, knext_rdata, inext_rdata;
  logic khead_we, ihead_we;
  logic [LW-1:0] khead_waddr, ihead_waddr, ihead_raddr;
  logic [PW-1:0] khead_wdata, ihead_wdata, khead_rdata, ihead_rdata;

  logic [PW-1:0] next_rd, head_rd;
  logic [difc_pkg::CHUNK_W-1:0] free_bits;
  logic [RW-1:0] refs_inc, refs_dec;
  logic out_free, accept;

  function automatic logic [difc_pkg::CHUNK_BIT_W-1:0] low_bit(
    input logic [difc_pkg::CHUNK_W-1:0] v
  );
    logic [difc_pkg::CHUNK_BIT_W-1:0] r;
    r = '0;
    for (int i = difc_pkg::CHUNK_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = difc_pkg::CHUNK_BIT_W'(i);
      end
    end
    return r;
  endfunction

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign free_bits = ~inuse[chunk*difc_pkg::CHUNK_W +: difc_pkg::CHUNK_W];
  assign next_rd   = usel ? knext_rdata : inext_rdata;
  assign head_rd   = usel ? khead_rdata : ihead_rdata;
  assign refs_inc  = (refs_rdata == difc_pkg::REFS_MAX) ? refs_rdata : refs_rdata + RW'(1);
  assign refs_dec  = (refs_rdata != '0) ? refs_rdata - RW'(1) : refs_rdata;

  assign knext_raddr = (state == S_UNX) ? s : (state == S_UWK) ? p[SW-1:0] : cur[SW-1:0];
  assign inext_raddr = knext_raddr;
  assign ihead_raddr = (state == S_IHEAD) ? probe_id[LW-1:0] : res_slot.ident[LW-1:0];

  assign slot_wdata = '{ident: probe_id, user_data: ud, key_c: kc, key_b: kb, key_a: ka};

  always_comb begin
    slot_we     = 1'b0;
    refs_we     = 1'b0;
    refs_wdata  = refs_inc;
    knext_we    = 1'b0;
    knext_waddr = s;
    knext_wdata = khd_save;
    inext_we    = 1'b0;
    inext_waddr = s;
    inext_wdata = ihd_save;
    khead_we    = 1'b0;
    khead_waddr = kline;
    khead_wdata = {1'b0, s};
    ihead_we    = 1'b0;
    ihead_waddr = probe_id[LW-1:0];
    ihead_wdata = {1'b0, s};
    case (state)
      S_CLEAR: begin
        khead_we    = 1'b1;
        khead_waddr = clr_idx;
        khead_wdata = difc_pkg::NIL_PTR;
        ihead_we    = 1'b1;
        ihead_waddr = clr_idx;
        ihead_wdata = difc_pkg::NIL_PTR;
      end
      S_ADDW: begin
        slot_we    = 1'b1;
        refs_we    = 1'b1;
        refs_wdata = RW'(1);
        knext_we   = 1'b1;
        inext_we   = 1'b1;
        khead_we   = 1'b1;
        ihead_we   = 1'b1;
      end
      S_REFUPD: begin
        refs_we    = 1'b1;
        refs_wdata = (op == difc_pkg::FUNC_DEL) ? refs_dec : refs_inc;
      end
      S_PUTC: begin
        refs_we    = !(linked[s] && refs_rdata == RW'(1));
        refs_wdata = refs_dec;
      end
      S_UHDC: begin
        if (head_rd == {1'b0, s}) begin
          khead_we    = usel;
          khead_wdata = snext;
          ihead_we    = !usel;
          ihead_waddr = res_slot.ident[LW-1:0];
          ihead_wdata = snext;
        end
      end
      S_UWKC: begin
        if (next_rd == {1'b0, s}) begin
          knext_we    = usel;
          knext_waddr = p[SW-1:0];
          knext_wdata = snext;
          inext_we    = !usel;
          inext_waddr = p[SW-1:0];
          inext_wdata = snext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      inuse        <= '0;
      linked       <= '0;
      linked_count <= '0;
      next_ident   <= difc_pkg::FIRST_IDENT;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + LW'(1);
          if (clr_idx == LW'(difc_pkg::HASH_LINES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op       <= s_tdata[2:0];
            ka       <= s_tdata[34:3];
            kb       <= s_tdata[66:35];
            kc       <= s_tdata[98:67];
            ud       <= s_tdata[130:99];
            probe_id <= s_tdata[146:131];
            s        <= s_tdata[154:147];
            cur      <= {1'b0, s_tdata[154:147]};
            chunk    <= '0;
            usel     <= 1'b0;
            res_show <= 1'b0;
            case (s_tdata[2:0])
              difc_pkg::FUNC_ADD, difc_pkg::FUNC_GET_KEY, difc_pkg::FUNC_DEL: begin
                state <= S_HASH1;
              end
              difc_pkg::FUNC_GET_ID: begin
                if (s_tdata[146:131] == '0) begin
                  res_status <= difc_pkg::ST_NOT_FOUND;
                  state      <= S_DONE;
                end else begin
                  state <= S_IHEAD;
                end
              end
              difc_pkg::FUNC_PUT: begin
                if (!inuse[s_tdata[154:147]]) begin
                  res_status <= difc_pkg::ST_BAD_HANDLE;
                  state      <= S_DONE;
                end else begin
                  state <= S_PUTRD;
                end
              end
              default: begin
                res_status <= difc_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        // key hash only needs the low line bits of the product
        S_HASH1: begin
          ab    <= LW'(ka[LW-1:0] * kb[LW-1:0]);
          state <= S_HASH2;
        end
        S_HASH2: begin
          kline <= LW'(ab * kc[LW-1:0]);
          state <= S_KHEAD;
        end
        S_KHEAD: state <= S_KHD;
        S_KHD: begin
          cur      <= khead_rdata;
          khd_save <= khead_rdata;
          state    <= S_KWALK;
        end
        S_KWALK: begin
          if (cur[PW-1]) begin
            if (op == difc_pkg::FUNC_ADD) begin
              state <= S_FREE;
            end else begin
              res_status <= difc_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            state <= S_KCMP;
          end
        end
        S_KCMP: begin
          if (slot_rdata.key_a == ka && slot_rdata.key_b == kb && slot_rdata.key_c == kc) begin
            res_slot <= slot_rdata;
            s        <= cur[SW-1:0];
            if (op == difc_pkg::FUNC_ADD) begin
              res_status <= difc_pkg::ST_KEY_EXISTS;
              state      <= S_DONE;
            end else if (op == difc_pkg::FUNC_GET_KEY) begin
              state <= S_REFRD;
            end else begin
              state <= S_UNX;
            end
          end else begin
            cur   <= knext_rdata;
            state <= S_KWALK;
          end
        end
        S_FREE: begin
          if (free_bits != '0) begin
            s        <= {chunk, low_bit(free_bits)};
            probe_id <= next_ident;
            state    <= S_IHEAD;
          end else if (chunk == difc_pkg::CHUNK_IDX_W'(difc_pkg::NUM_CHUNK - 1)) begin
            res_status <= difc_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            chunk <= chunk + difc_pkg::CHUNK_IDX_W'(1);
          end
        end
        S_IHEAD: state <= S_IHD;
        S_IHD: begin
          cur      <= ihead_rdata;
          ihd_save <= ihead_rdata;
          state    <= S_IWALK;
        end
        S_IWALK: begin
          if (cur[PW-1]) begin
            if (op == difc_pkg::FUNC_ADD) begin
              state <= S_ADDW;
            end else begin
              res_status <= difc_pkg::ST_NOT_FOUND;
              state      <= S_DONE;
            end
          end else begin
            state <= S_ICMP;
          end
        end
        S_ICMP: begin
          if (slot_rdata.ident == probe_id) begin
            if (op == difc_pkg::FUNC_ADD) begin
              // id taken: probe the next one
              probe_id <= (probe_id == difc_pkg::LAST_IDENT) ?
                          difc_pkg::FIRST_IDENT : probe_id + IW'(1);
              state    <= S_IHEAD;
            end else begin
              res_slot <= slot_rdata;
              s        <= cur[SW-1:0];
              state    <= S_REFRD;
            end
          end else begin
            cur   <= inext_rdata;
            state <= S_IWALK;
          end
        end
        S_ADDW: begin
          inuse[s]     <= 1'b1;
          linked[s]    <= 1'b1;
          linked_count <= linked_count + difc_pkg::CNT_W'(1);
          next_ident   <= (probe_id == difc_pkg::LAST_IDENT) ?
                          difc_pkg::FIRST_IDENT : probe_id + IW'(1);
          res_slot     <= slot_wdata;
          res_refs     <= RW'(1);
          res_status   <= difc_pkg::ST_OK;
          res_show     <= 1'b1;
          state        <= S_DONE;
        end
        S_REFRD: state <= S_REFUPD;
        S_REFUPD: begin
          res_status <= difc_pkg::ST_OK;
          res_show   <= 1'b1;
          if (op == difc_pkg::FUNC_DEL) begin
            res_refs  <= refs_dec;
            linked[s] <= 1'b0;
            if (refs_dec == '0) begin
              inuse[s] <= 1'b0;
            end
            if (linked_count != '0) begin
              linked_count <= linked_count - difc_pkg::CNT_W'(1);
            end
          end else begin
            res_refs <= refs_inc;
          end
          state <= S_DONE;
        end
        S_UNX: state <= S_UHD;
        S_UHD: begin
          snext <= next_rd;
          state <= S_UHDC;
        end
        S_UHDC: begin
          if (head_rd == {1'b0, s}) begin
            state <= S_UEND;
          end else begin
            p     <= head_rd;
            state <= head_rd[PW-1] ? S_UEND : S_UWK;
          end
        end
        S_UWK: state <= S_UWKC;
        S_UWKC: begin
          if (next_rd == {1'b0, s} || next_rd[PW-1]) begin
            state <= S_UEND;
          end else begin
            p     <= next_rd;
            state <= S_UWK;
          end
        end
        S_UEND: begin
          if (!usel) begin
            usel  <= 1'b1;
            state <= S_UNX;
          end else begin
            state <= S_REFRD;
          end
        end
        S_PUTRD: state <= S_PUTC;
        S_PUTC: begin
          // the table's own reference cannot be put
          if (linked[s] && refs_rdata == RW'(1)) begin
            res_status <= difc_pkg::ST_BAD_HANDLE;
          end else begin
            res_status <= difc_pkg::ST_OK;
            res_show   <= 1'b1;
            res_slot   <= slot_rdata;
            res_refs   <= refs_dec;
            if (refs_dec == '0) begin
              inuse[s] <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            o_status <= res_status;
            o_cnt    <= linked_count;
            o_id     <= res_show ? res_slot.ident : '0;
            o_handle <= res_show ? s : '0;
            o_ka     <= res_show ? res_slot.key_a : '0;
            o_kb     <= res_show ? res_slot.key_b : '0;
            o_kc     <= res_show ? res_slot.key_c : '0;
            o_ud     <= res_show ? res_slot.user_data : '0;
            o_refs   <= res_show ? res_refs : '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, o_cnt, o_refs, o_ud, o_kc, o_kb, o_ka, o_handle, o_id, o_status};

  difc_ram #(.WIDTH(difc_pkg::SLOT_DATA_W), .DEPTH(difc_pkg::CAPACITY)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(s), .wdata(slot_wdata),
    .raddr(cur[SW-1:0]), .rdata(slot_rdata)
  );

  difc_ram #(.WIDTH(RW), .DEPTH(difc_pkg::CAPACITY)) u_refs_ram (
    .clk(clk), .we(refs_we), .waddr(s), .wdata(refs_wdata),
    .raddr(s), .rdata(refs_rdata)
  );

  difc_ram #(.WIDTH(PW), .DEPTH(difc_pkg::CAPACITY)) u_knext_ram (
    .clk(clk), .we(knext_we), .waddr(knext_waddr), .wdata(knext_wdata),
    .raddr(knext_raddr), .rdata(knext_rdata)
  );

  difc_ram #(.WIDTH(PW), .DEPTH(difc_pkg::CAPACITY)) u_inext_ram (
    .clk(clk), .we(inext_we), .waddr(inext_waddr), .wdata(inext_wdata),
    .raddr(inext_raddr), .rdata(inext_rdata)
  );

  difc_ram #(.WIDTH(PW), .DEPTH(difc_pkg::HASH_LINES)) u_khead_ram (
    .clk(clk), .we(khead_we), .waddr(khead_waddr), .wdata(khead_wdata),
    .raddr(kline), .rdata(khead_rdata)
  );

  difc_ram #(.WIDTH(PW), .DEPTH(difc_pkg::HASH_LINES)) u_ihead_ram (
    .clk(clk), .we(ihead_we), .waddr(ihead_waddr), .wdata(ihead_wdata),
    .raddr(ihead_raddr), .rdata(ihead_rdata)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the dual-index refcounted flow table core.
`timescale 1ns / 1ps
module testbench;

  localparam int TAB_SLOTS = 256;
  localparam int ID_TOP    = 65535;
  localparam logic [difc_pkg::FUNC_W-1:0] FUNC_COUNT = 3'd5;
  localparam logic [difc_pkg::FUNC_W-1:0] FUNC_ALT6  = 3'd6;
  localparam logic [difc_pkg::FUNC_W-1:0] FUNC_ALT7  = 3'd7;
  localparam int POOL_N = 48;

  typedef struct {
    logic [difc_pkg::FUNC_W-1:0] func;
    logic [31:0]       ka, kb, kc, ud;
    logic [15:0]       lid;
    logic [7:0]        hnd;
  } flow_req_t;

  typedef struct {
    logic [difc_pkg::STATUS_W-1:0] st;
    logic [15:0]         id;
    logic [7:0]          hnd;
    logic [31:0]         ka, kb, kc, ud;
    logic [15:0]         refs;
    logic [8:0]          used;
  } flow_res_t;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [difc_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [difc_pkg::OUT_DATA_W-1:0] m_tdata;

  dual_index_refcounted_flow_table_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predictor copy of the table
  logic [31:0] tab_ka[TAB_SLOTS], tab_kb[TAB_SLOTS], tab_kc[TAB_SLOTS], tab_ud[TAB_SLOTS];
  logic [15:0] tab_id[TAB_SLOTS];
  int          tab_refs[TAB_SLOTS];
  bit          tab_linked[TAB_SLOTS];
  int          id_cursor;
  int          linked_total;

  flow_res_t   pending_results[$];
  int          errors;
  int          results_seen;
  int          send_idle_pct, recv_stall_pct;
  logic [31:0] pool_a[POOL_N], pool_b[POOL_N], pool_c[POOL_N];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout, %0d results still pending", pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int slot_by_key(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    for (int s = 0; s < TAB_SLOTS; s++)
      if (tab_linked[s] && tab_ka[s] == a && tab_kb[s] == b && tab_kc[s] == c) return s;
    return -1;
  endfunction

  function automatic int slot_by_id(int id);
    for (int s = 0; s < TAB_SLOTS; s++)
      if (tab_linked[s] && tab_id[s] == id) return s;
    return -1;
  endfunction

  function automatic flow_res_t table_result(logic [difc_pkg::STATUS_W-1:0] st, int s);
    flow_res_t r;
    r = '{st: st, id: '0, hnd: '0, ka: '0, kb: '0, kc: '0, ud: '0, refs: '0,
          used: linked_total[8:0]};
    if (s >= 0) begin
      r.id = tab_id[s]; r.hnd = s[7:0];
      r.ka = tab_ka[s]; r.kb = tab_kb[s]; r.kc = tab_kc[s]; r.ud = tab_ud[s];
      r.refs = tab_refs[s][15:0];
    end
    return r;
  endfunction

  function automatic flow_res_t apply_request(flow_req_t q);
    int s, id, n;
    case (q.func)
      difc_pkg::FUNC_ADD: begin
        if (slot_by_key(q.ka, q.kb, q.kc) >= 0)
          return table_result(difc_pkg::ST_KEY_EXISTS, -1);
        s = 0;
        while (s < TAB_SLOTS && tab_refs[s] != 0) s++;
        if (s >= TAB_SLOTS || linked_total >= ID_TOP)
          return table_result(difc_pkg::ST_FULL, -1);
        id = id_cursor;
        if (id < 1 || id > ID_TOP) id = 1;
        for (n = 0; n < ID_TOP && slot_by_id(id) >= 0; n++) begin
          id++;
          if (id > ID_TOP) id = 1;
        end
        id_cursor = (id + 1 > ID_TOP) ? 1 : id + 1;
        tab_ka[s] = q.ka; tab_kb[s] = q.kb; tab_kc[s] = q.kc; tab_ud[s] = q.ud;
        tab_id[s] = id[15:0]; tab_refs[s] = 1; tab_linked[s] = 1;
        linked_total++;
        return table_result(difc_pkg::ST_OK, s);
      end
      difc_pkg::FUNC_GET_KEY, difc_pkg::FUNC_GET_ID: begin
        s = (q.func == difc_pkg::FUNC_GET_KEY) ? slot_by_key(q.ka, q.kb, q.kc) :
                                                 slot_by_id(q.lid);
        if (s < 0) return table_result(difc_pkg::ST_NOT_FOUND, -1);
        if (tab_refs[s] < 'hFFFF) tab_refs[s]++;
        return table_result(difc_pkg::ST_OK, s);
      end
      difc_pkg::FUNC_PUT: begin
        s = q.hnd;
        if (tab_refs[s] == 0 || (tab_linked[s] && tab_refs[s] == 1))
          return table_result(difc_pkg::ST_BAD_HANDLE, -1);
        tab_refs[s]--;
        return table_result(difc_pkg::ST_OK, s);
      end
      difc_pkg::FUNC_DEL: begin
        s = slot_by_key(q.ka, q.kb, q.kc);
        if (s < 0) return table_result(difc_pkg::ST_NOT_FOUND, -1);
        tab_linked[s] = 0;
        if (linked_total > 0) linked_total--;
        if (tab_refs[s] > 0) tab_refs[s]--;
        return table_result(difc_pkg::ST_OK, s);
      end
      default: return table_result(difc_pkg::ST_OK, -1);
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    flow_res_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("result %0d arrived with nothing pending", results_seen);
        end else begin
          e = pending_results.pop_front();
          if (m_tdata[2:0] !== e.st)
            report("status", 32'(m_tdata[2:0]), 32'(e.st));
          if (m_tdata[18:3] !== e.id)
            report("entry_id", 32'(m_tdata[18:3]), 32'(e.id));
          if (m_tdata[26:19] !== e.hnd)
            report("handle", 32'(m_tdata[26:19]), 32'(e.hnd));
          if (m_tdata[58:27] !== e.ka)    report("key_a", m_tdata[58:27], e.ka);
          if (m_tdata[90:59] !== e.kb)    report("key_b", m_tdata[90:59], e.kb);
          if (m_tdata[122:91] !== e.kc)   report("key_c", m_tdata[122:91], e.kc);
          if (m_tdata[154:123] !== e.ud)  report("user_data", m_tdata[154:123], e.ud);
          if (m_tdata[170:155] !== e.refs)
            report("refs", 32'(m_tdata[170:155]), 32'(e.refs));
          if (m_tdata[179:171] !== e.used)
            report("entries_in_use", 32'(m_tdata[179:171]), 32'(e.used));
        end
      end
    end
  end

  task automatic send_request(flow_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, q.hnd, q.lid, q.ud, q.kc, q.kb, q.ka, q.func};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_request(q));
  endtask

  function automatic flow_req_t make_req(logic [difc_pkg::FUNC_W-1:0] f, logic [31:0] a,
                                         logic [31:0] b, logic [31:0] c);
    flow_req_t q;
    q.func = f; q.ka = a; q.kb = b; q.kc = c;
    q.ud = $urandom; q.lid = 16'($urandom); q.hnd = 8'($urandom);
    return q;
  endfunction

  task automatic send_op(logic [difc_pkg::FUNC_W-1:0] f, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c);
    send_request(make_req(f, a, b, c));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed();
    flow_req_t q;
    send_op(FUNC_COUNT, 0, 0, 0);
    send_op(FUNC_ALT6, 0, 0, 0);
    send_op(FUNC_ALT7, '1, '1, '1);
    send_op(difc_pkg::FUNC_ADD, '1, '1, '1);
    send_op(difc_pkg::FUNC_ADD, 0, 0, 0);
    send_op(difc_pkg::FUNC_ADD, '1, '1, '1);             // duplicate key
    send_op(difc_pkg::FUNC_GET_KEY, '1, '1, '1);
    send_op(difc_pkg::FUNC_GET_KEY, 1, 2, 3);            // miss
    q = make_req(difc_pkg::FUNC_GET_ID, 0, 0, 0); q.lid = 16'd0;    send_request(q);
    q = make_req(difc_pkg::FUNC_GET_ID, 0, 0, 0); q.lid = 16'hFFFF; send_request(q);
    q = make_req(difc_pkg::FUNC_GET_ID, 0, 0, 0); q.lid = 16'd2;    send_request(q);
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd1;   send_request(q); // owned by table
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd255; send_request(q); // free slot
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd0;   send_request(q);
    send_op(difc_pkg::FUNC_DEL, 0, 0, 0);
    send_op(difc_pkg::FUNC_DEL, 0, 0, 0);                // already gone
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd0;   send_request(q); // linked, 1
    send_op(difc_pkg::FUNC_GET_KEY, '1, '1, '1);
    send_op(difc_pkg::FUNC_DEL, '1, '1, '1);
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd0;   send_request(q);
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd0;   send_request(q); // already freed
    q = make_req(difc_pkg::FUNC_PUT, 0, 0, 0); q.hnd = 8'd0;   send_request(q);
    send_op(FUNC_COUNT, 0, 0, 0);
  endtask

  task automatic test_refcount_gets();
    send_op(difc_pkg::FUNC_ADD, 32'h5A5A_0001, 32'h0000_0003, 32'h1234_5678);
    for (int i = 0; i < 40; i++)
      send_op(difc_pkg::FUNC_GET_KEY, 32'h5A5A_0001, 32'h0000_0003, 32'h1234_5678);
    send_op(difc_pkg::FUNC_DEL, 32'h5A5A_0001, 32'h0000_0003, 32'h1234_5678);
  endtask

  task automatic test_fill_and_empty();
    logic [31:0] fa[TAB_SLOTS + 4];
    for (int i = 0; i < TAB_SLOTS + 4; i++) begin
      fa[i] = $urandom;
      send_op(difc_pkg::FUNC_ADD, fa[i], i, (i % 3 == 0) ? 32'd0 : 32'd7);  // c = 0 crowds a chain
    end
    send_op(difc_pkg::FUNC_ADD, fa[5], 5, 7);
    // pause until the table has answered everything
    wait_drained();
    for (int i = TAB_SLOTS + 3; i >= 0; i--)
      send_op(difc_pkg::FUNC_DEL, fa[i], i, (i % 3 == 0) ? 32'd0 : 32'd7);
    send_op(FUNC_COUNT, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    flow_req_t q;
    int k, r, s;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(POOL_N - 1);
      q = make_req(FUNC_COUNT, pool_a[k], pool_b[k], pool_c[k]);
      if ($urandom_range(15) == 0) begin
        q.ka = $urandom; q.kb = $urandom; q.kc = $urandom;
      end
      r = $urandom_range(99);
      if (r < 30)      q.func = difc_pkg::FUNC_ADD;
      else if (r < 48) q.func = difc_pkg::FUNC_GET_KEY;
      else if (r < 63) q.func = difc_pkg::FUNC_GET_ID;
      else if (r < 80) q.func = difc_pkg::FUNC_PUT;
      else if (r < 95) q.func = difc_pkg::FUNC_DEL;
      else             q.func = 3'($urandom_range(FUNC_COUNT, FUNC_ALT7));
      if (q.func == difc_pkg::FUNC_GET_ID && $urandom_range(3) != 0) begin
        for (int t = 0; t < 8; t++) begin
          s = $urandom_range(TAB_SLOTS - 1);
          if (tab_linked[s]) begin
            q.lid = tab_id[s];
            break;
          end
        end
      end
      if (q.func == difc_pkg::FUNC_PUT && $urandom_range(3) != 0) begin
        for (int t = 0; t < 8; t++) begin
          s = $urandom_range(TAB_SLOTS - 1);
          if (tab_refs[s] != 0) begin
            q.hnd = s[7:0];
            break;
          end
        end
      end
      send_request(q);
    end
  endtask

  initial begin
    errors = 0; results_seen = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int s = 0; s < TAB_SLOTS; s++) begin
      tab_refs[s] = 0; tab_linked[s] = 0;
    end
    id_cursor = 1; linked_total = 0;
    for (int i = 0; i < POOL_N; i++) begin
      pool_a[i] = $urandom; pool_b[i] = $urandom;
      pool_c[i] = (i % 4 == 0) ? 32'd0 : $urandom;
    end
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_refcount_gets();
    test_fill_and_empty();
    test_random(200);
    send_idle_pct = 83;
    test_random(200);
    send_idle_pct = 0; recv_stall_pct = 83;
    test_random(200);
    send_idle_pct = 36; recv_stall_pct = 36;
    test_random(200);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(60);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("ran adds, lookups by key and id, puts, deletes, counts, a full table and");
    $display("several sender and receiver stall mixes: %0d results checked", results_seen);
    if (errors == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/difc_pkg.sv
src/difc_ram.sv
src/dual_index_refcounted_flow_table_core.sv
tb/testbench.sv
